/* hw/rtl/cdsr_pkg.sv */
// ----------------------------------------------------------------------------
// cdsr_pkg - shared types and constants for the speed ramp and thermostat core
// Field widths, command letters, phase and mode codes, and the fixed-point
// constants of the temperature conversion.
// ----------------------------------------------------------------------------
package cdsr_pkg;

    // Design defaults handed to the top-level parameters
    localparam int CHANNELS_DEF  = 4;
    localparam int FREQ_BITS_DEF = 20;

    // Word field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int SCH_W    = 2;
    localparam int RAW_W    = 10;
    localparam int HEAT_W   = 4;
    localparam int CFREQ_W  = 20;
    localparam int PHASE_W  = 2;
    localparam int DIV_W    = 8;

    // Frame layout
    localparam int FRAME_LEN = 5;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam int BIDX_W    = $clog2(FRAME_LEN - 1);
    localparam int SEL_W     = 3;
    localparam int VALUE_W   = 11;
    localparam int SETPT_W   = 10;
    localparam int TEMP_W    = 8;
    localparam int TICK_W    = 8;
    localparam int TGT_SHIFT = 9;

    // Reset values
    localparam int DIV_RESET  = 23;
    localparam int FREQ_RESET = 100;

    // ASCII codes
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [BYTE_W-1:0] ASCII_ONE  = 8'd49;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'd57;
    localparam logic [BYTE_W-1:0] LTR_SETPT  = 8'd116;
    localparam logic [BYTE_W-1:0] LTR_RUN_ON = 8'd105;
    localparam logic [BYTE_W-1:0] LTR_RUN_OFF = 8'd101;
    localparam logic [BYTE_W-1:0] LTR_TARGET = 8'd99;
    localparam logic [BYTE_W-1:0] LTR_START  = 8'd97;
    localparam logic [BYTE_W-1:0] LTR_BRAKE  = 8'd100;

    // Decimal weights of the three frame digits
    localparam int DIG_HUND = 100;
    localparam int DIG_TENS = 10;

    // Temperature conversion: floor((raw*SCALE + OFFSET) / DIV) done as one
    // multiply by a rounded-up reciprocal, exact for sums below 2^24
    localparam longint unsigned TC_SCALE  = 10000;
    localparam longint unsigned TC_OFFSET = 874340;
    localparam longint unsigned TC_DIV    = 45505;
    localparam int              TC_SHIFT  = 40;
    localparam int              TC_PROD_W = 50;
    localparam longint unsigned TC_RECIP  =
        ((64'd1 << TC_SHIFT) + TC_DIV - 64'd1) / TC_DIV;
    localparam longint unsigned TC_GAIN   = TC_SCALE * TC_RECIP;
    localparam longint unsigned TC_BIAS   = TC_OFFSET * TC_RECIP;

    // Event kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_BYTE   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Decoded frame commands
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_SETPT   = 3'd1,
        CMD_RUN_ON  = 3'd2,
        CMD_RUN_OFF = 3'd3,
        CMD_TARGET  = 3'd4,
        CMD_START   = 3'd5,
        CMD_BRAKE   = 3'd6
    } t_cmd;

    // Ramp phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_CMP  = 4'b0010,
        PH_UP   = 4'b0100,
        PH_DOWN = 4'b1000
    } t_phase;

    // Phase codes as seen on the result word
    localparam logic [PHASE_W-1:0] PCODE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PCODE_CMP  = 2'd1;
    localparam logic [PHASE_W-1:0] PCODE_UP   = 2'd2;
    localparam logic [PHASE_W-1:0] PCODE_DOWN = 2'd3;

    // Motor mode, one-hot
    typedef enum logic [2:0] {
        MODE_NONE  = 3'b001,
        MODE_RUN   = 3'b010,
        MODE_BRAKE = 3'b100
    } t_mode;

    // Registered input word
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   rx_byte;
        logic [SCH_W-1:0]    sample_channel;
        logic [RAW_W-1:0]    sample_raw;
    } t_item;

    // Frame decoder to control unit
    typedef struct packed {
        logic               done;
        t_cmd               cmd;
        logic [SEL_W-1:0]   sel;
        logic [VALUE_W-1:0] value;
    } t_frame;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

endpackage

/* hw/rtl/cdsr_in_if.sv */
// ----------------------------------------------------------------------------
// cdsr_in_if - event channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface cdsr_in_if;
    import cdsr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   rx_byte;
    logic [SCH_W-1:0]    sample_channel;
    logic [RAW_W-1:0]    sample_raw;

    modport source (output valid, action, rx_byte, sample_channel, sample_raw,
                    input ready);
    modport sink   (input valid, action, rx_byte, sample_channel, sample_raw,
                    output ready);
endinterface

/* hw/rtl/cdsr_out_if.sv */
// ----------------------------------------------------------------------------
// cdsr_out_if - status channel
// Valid/ready channel carrying one status word per event.
// ----------------------------------------------------------------------------
interface cdsr_out_if;
    import cdsr_pkg::*;

    logic               valid;
    logic               ready;
    logic [HEAT_W-1:0]  heater_bits;
    logic               motor_enabled;
    logic               pulse_output_on;
    logic               done_lamp;
    logic [CFREQ_W-1:0] current_frequency;
    logic [PHASE_W-1:0] ramp_phase;
    logic               running;

    modport source (output valid, heater_bits, motor_enabled, pulse_output_on,
                    done_lamp, current_frequency, ramp_phase, running,
                    input ready);
    modport sink   (input valid, heater_bits, motor_enabled, pulse_output_on,
                    done_lamp, current_frequency, ramp_phase, running,
                    output ready);
endinterface

/* hw/rtl/cdsr_in_reg.sv */
// ----------------------------------------------------------------------------
// cdsr_in_reg - input register
// Captures one event word and holds it until the control unit takes it.
// ----------------------------------------------------------------------------
module cdsr_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cdsr_in_if.sink         i_in,
    input  logic            i_take,
    output logic            o_valid,
    output cdsr_pkg::t_item o_item
);
    import cdsr_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Accept when empty or when the held word leaves this cycle
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= '{action:         i_in.action,
                        rx_byte:        i_in.rx_byte,
                        sample_channel: i_in.sample_channel,
                        sample_raw:     i_in.sample_raw};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

/* hw/rtl/cdsr_frame.sv */
// ----------------------------------------------------------------------------
// cdsr_frame - frame assembler and command decoder
// Gathers received bytes into five-byte frames and decodes the command when
// the last byte arrives.
// ----------------------------------------------------------------------------
module cdsr_frame #(
    parameter int CHANNELS = cdsr_pkg::CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [cdsr_pkg::BYTE_W-1:0] i_byte,
    output cdsr_pkg::t_frame          o_frame
);
    import cdsr_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [BYTE_W-1:0] r_bytes [FRAME_LEN-1];
    logic              last;
    logic              ch_ok;
    logic              digits_ok;
    logic [BYTE_W-1:0] b0, b1, b2, b3, b4;

    assign last = (r_count == CNT_W'(FRAME_LEN - 1));

    // Count bytes; wrap after the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= last ? '0 : r_count + CNT_W'(1);
        end
    end

    // Store the leading bytes; the final byte is used live
    always_ff @(posedge i_clk) begin
        if (i_fire && !last) begin
            r_bytes[r_count[BIDX_W-1:0]] <= i_byte;
        end
    end

    assign b0 = r_bytes[0];
    assign b1 = r_bytes[1];
    assign b2 = r_bytes[2];
    assign b3 = r_bytes[3];
    assign b4 = i_byte;

    assign ch_ok     = (b1 > ASCII_ZERO) && (b1 <= BYTE_W'(int'(ASCII_ZERO) + CHANNELS));
    assign digits_ok = is_digit(b2) && is_digit(b3) && is_digit(b4);

    // Decode the command letter
    always_comb begin
        o_frame.done  = i_fire && last;
        o_frame.sel   = SEL_W'(b1 - ASCII_ONE);
        o_frame.value = VALUE_W'(b2[3:0]) * VALUE_W'(DIG_HUND)
                      + VALUE_W'(b3[3:0]) * VALUE_W'(DIG_TENS)
                      + VALUE_W'(b4[3:0]);
        unique case (b0)
            LTR_SETPT:   o_frame.cmd = (ch_ok && digits_ok) ? CMD_SETPT : CMD_NONE;
            LTR_RUN_ON:  o_frame.cmd = CMD_RUN_ON;
            LTR_RUN_OFF: o_frame.cmd = CMD_RUN_OFF;
            LTR_TARGET:  o_frame.cmd = CMD_TARGET;
            LTR_START:   o_frame.cmd = CMD_START;
            LTR_BRAKE:   o_frame.cmd = CMD_BRAKE;
            default:     o_frame.cmd = CMD_NONE;
        endcase
    end
endmodule

/* hw/rtl/cdsr_tconv.sv */
// ----------------------------------------------------------------------------
// cdsr_tconv - temperature conversion
// Converts a raw converter value to degrees by a single reciprocal multiply.
// ----------------------------------------------------------------------------
module cdsr_tconv (
    input  logic [cdsr_pkg::RAW_W-1:0]  i_raw,
    output logic [cdsr_pkg::TEMP_W-1:0] o_temp
);
    import cdsr_pkg::*;

    logic [TC_PROD_W-1:0] prod;

    // Gain and bias carry the reciprocal already; the shift drops the fraction
    assign prod   = TC_PROD_W'(i_raw) * TC_PROD_W'(TC_GAIN) + TC_PROD_W'(TC_BIAS);
    assign o_temp = prod[TC_SHIFT +: TEMP_W];
endmodule

/* hw/rtl/cdsr_ctrl.sv */
// ----------------------------------------------------------------------------
// cdsr_ctrl - control unit and result register
// Applies one event per cycle, unless a stalled result word holds it, to the
// thermostat and ramp state and loads the resulting status word.
// ----------------------------------------------------------------------------
module cdsr_ctrl #(
    parameter int CHANNELS  = cdsr_pkg::CHANNELS_DEF,
    parameter int FREQ_BITS = cdsr_pkg::FREQ_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cdsr_pkg::DIV_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    input  cdsr_pkg::t_item             i_item,
    input  cdsr_pkg::t_frame            i_frame,
    input  logic [cdsr_pkg::TEMP_W-1:0] i_temp,
    output logic                        o_take,
    cdsr_out_if.source                  o_out
);
    import cdsr_pkg::*;

    localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;

    // Configuration and state
    logic [DIV_W-1:0]     r_div;
    logic [SETPT_W-1:0]   r_setpt [CHANNELS];
    logic [TEMP_W-1:0]    r_temp  [CHANNELS];
    logic [FREQ_BITS-1:0] r_target, n_target;
    logic [FREQ_BITS-1:0] r_freq, n_freq;
    t_phase               r_phase, n_phase;
    t_mode                r_mode, n_mode;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic                 r_running, n_running;
    logic                 r_lamp, n_lamp;
    logic                 r_enabled, n_enabled;
    logic                 r_pulse, n_pulse;
    logic [CHANNELS-1:0]  r_heat, n_heat;

    // Result register
    logic                 r_out_valid;
    logic [HEAT_W-1:0]    r_out_heat, n_out_heat;
    logic [PHASE_W-1:0]   r_out_phase, n_out_phase;

    logic [TICK_W-1:0]    tick_inc;
    logic [FREQ_BITS-1:0] freq_up, freq_dn;

    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    assign tick_inc = r_tick + TICK_W'(1);
    assign freq_up  = (r_freq != FREQ_MAX) ? r_freq + FREQ_BITS'(1) : r_freq;
    assign freq_dn  = (r_freq != '0) ? r_freq - FREQ_BITS'(1) : r_freq;

    // Next state for the event held in the input register
    always_comb begin
        n_target  = r_target;
        n_freq    = r_freq;
        n_phase   = r_phase;
        n_mode    = r_mode;
        n_tick    = r_tick;
        n_running = r_running;
        n_lamp    = r_lamp;
        n_enabled = r_enabled;
        n_pulse   = r_pulse;
        n_heat    = r_heat;
        case (i_item.action)
            ACT_BYTE: begin
                if (i_frame.done) begin
                    unique case (i_frame.cmd)
                        CMD_RUN_ON: begin
                            n_running = 1'b1;
                            n_lamp    = 1'b0;
                        end
                        CMD_RUN_OFF: begin
                            n_running = 1'b0;
                        end
                        CMD_TARGET: begin
                            n_target = FREQ_BITS'(i_frame.value) << TGT_SHIFT;
                            n_phase  = PH_CMP;
                            n_lamp   = 1'b0;
                        end
                        CMD_START: begin
                            n_target = FREQ_BITS'(i_frame.value) << TGT_SHIFT;
                            n_phase  = PH_CMP;
                            n_lamp   = 1'b0;
                            n_mode   = MODE_RUN;
                            n_pulse  = 1'b1;
                        end
                        CMD_BRAKE: begin
                            n_mode = MODE_BRAKE;
                            n_lamp = 1'b0;
                        end
                        default: begin
                            // setpoints are written in the clocked block
                        end
                    endcase
                end
            end
            ACT_TICK: begin
                if (r_running) begin
                    // Thermostat: heat while below setpoint
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_heat[c] = r_setpt[c] > SETPT_W'(r_temp[c]);
                    end
                    if (tick_inc >= r_div) begin
                        n_tick = '0;
                        // Ramp step
                        unique case (r_mode)
                            MODE_RUN: begin
                                n_enabled = 1'b1;
                                unique case (r_phase)
                                    PH_CMP: begin
                                        if (r_target > r_freq) begin
                                            n_phase = PH_UP;
                                        end else if (r_target < r_freq) begin
                                            n_phase = PH_DOWN;
                                        end
                                    end
                                    PH_UP: begin
                                        n_freq = freq_up;
                                        if (freq_up >= r_target) begin
                                            n_freq  = r_target;
                                            n_phase = PH_IDLE;
                                            n_lamp  = 1'b1;
                                        end
                                    end
                                    PH_DOWN: begin
                                        n_freq = freq_dn;
                                        if (freq_dn <= r_target) begin
                                            n_freq  = r_target;
                                            n_phase = PH_IDLE;
                                            n_lamp  = 1'b1;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            MODE_BRAKE: begin
                                if (r_freq != '0) begin
                                    n_freq = freq_dn;
                                end else begin
                                    n_lamp    = 1'b1;
                                    n_enabled = 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        n_tick = tick_inc;
                    end
                end
            end
            default: begin
                // samples update the temperature table in the clocked block
            end
        endcase
    end

    // Encode the status word
    always_comb begin
        n_out_heat = '0;
        for (int b = 0; b < HEAT_W; b++) begin
            if (b < CHANNELS) begin
                n_out_heat[b] = n_heat[b];
            end
        end
        unique case (n_phase)
            PH_IDLE: n_out_phase = PCODE_IDLE;
            PH_CMP:  n_out_phase = PCODE_CMP;
            PH_UP:   n_out_phase = PCODE_UP;
            PH_DOWN: n_out_phase = PCODE_DOWN;
            default: n_out_phase = PCODE_IDLE;
        endcase
    end

    // Hold the ramp divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= DIV_W'(DIV_RESET);
        end else if (i_cfg_we) begin
            r_div <= i_cfg_wdata;
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= FREQ_BITS'(FREQ_RESET);
            r_freq    <= FREQ_BITS'(FREQ_RESET);
            r_phase   <= PH_IDLE;
            r_mode    <= MODE_NONE;
            r_tick    <= '0;
            r_running <= 1'b0;
            r_lamp    <= 1'b0;
            r_enabled <= 1'b0;
            r_pulse   <= 1'b0;
            r_heat    <= '0;
        end else if (o_take) begin
            r_target  <= n_target;
            r_freq    <= n_freq;
            r_phase   <= n_phase;
            r_mode    <= n_mode;
            r_tick    <= n_tick;
            r_running <= n_running;
            r_lamp    <= n_lamp;
            r_enabled <= n_enabled;
            r_pulse   <= n_pulse;
            r_heat    <= n_heat;
        end
    end

    // Setpoint and temperature tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_setpt[c] <= '0;
                r_temp[c]  <= '0;
            end
        end else if (o_take) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (i_item.action == ACT_BYTE && i_frame.done &&
                    i_frame.cmd == CMD_SETPT && i_frame.sel == SEL_W'(c)) begin
                    r_setpt[c] <= SETPT_W'(i_frame.value);
                end
                if (i_item.action == ACT_SAMPLE &&
                    int'(i_item.sample_channel) == c) begin
                    r_temp[c] <= i_temp;
                end
            end
        end
    end

    // Result valid: set on take, drop when taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_heat  <= n_out_heat;
            r_out_phase <= n_out_phase;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.heater_bits       = r_out_heat;
    assign o_out.ramp_phase        = r_out_phase;
    assign o_out.motor_enabled     = r_enabled;
    assign o_out.pulse_output_on   = r_pulse;
    assign o_out.done_lamp         = r_lamp;
    assign o_out.current_frequency = r_freq[CFREQ_W-1:0];
    assign o_out.running           = r_running;
endmodule

/* hw/rtl/command_driven_speed_ramp_and_thermostat_core.sv */
// ----------------------------------------------------------------------------
// command_driven_speed_ramp_and_thermostat_core - top level
// Serial command frames, control ticks and temperature samples drive a
// four-channel on/off thermostat and a stepper speed ramp.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         word
//  i_in      in   valid / ready     action, rx_byte, sample_channel, sample_raw
//  o_out     out  valid / ready     heater and motor status, frequency, phase
//  i_cfg_*   in   write enable      ramp divider
//
//  Each event passes the input register, then the update logic into the result
//  register; one event enters every cycle while the result is not stalled.
//  The update path is set by the temperature reciprocal multiply.
//  Synchronous active-low reset; no clearing pass is needed.
//  A stalled result holds the state; the input register keeps its word, or takes
//  one if it was empty, and then drops ready until the result word leaves.
// ----------------------------------------------------------------------------
module command_driven_speed_ramp_and_thermostat_core #(
    parameter int CHANNELS  = cdsr_pkg::CHANNELS_DEF,
    parameter int FREQ_BITS = cdsr_pkg::FREQ_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cdsr_pkg::DIV_W-1:0] i_cfg_wdata,
    cdsr_in_if.sink                    i_in,
    cdsr_out_if.source                 o_out
);
    import cdsr_pkg::*;

    logic               in_valid;
    t_item              in_item;
    logic               take;
    t_frame             frame;
    logic [TEMP_W-1:0]  temp;

    // Input register
    cdsr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // Frame assembly
    cdsr_frame #(
        .CHANNELS (CHANNELS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (take && (in_item.action == ACT_BYTE)),
        .i_byte  (in_item.rx_byte),
        .o_frame (frame)
    );

    // Temperature conversion
    cdsr_tconv u_tconv (
        .i_raw  (in_item.sample_raw),
        .o_temp (temp)
    );

    // State update and result register
    cdsr_ctrl #(
        .CHANNELS  (CHANNELS),
        .FREQ_BITS (FREQ_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_frame     (frame),
        .i_temp      (temp),
        .o_take      (take),
        .o_out       (o_out)
    );
endmodule
